>>> design/numsch_pkg.sv
`default_nettype none

package numsch_pkg;

	// Field and register widths.
	localparam int VALUE_W    = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ENERGY_W   = 31;
	localparam int H2_W       = 32;
	localparam int ACTION_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Datapath widths of the shared unit.
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int QUO_W  = 32;
	localparam int CMAG_W = 49;
	localparam int ACC_W  = 82;
	localparam int REM_W  = CMAG_W + 1;
	localparam int D3_W   = 64;

	// Actions.
	localparam logic [ACTION_W-1:0] ACT_LOAD_OLDER = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_PREV  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_STEP       = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_H_SQUARED = 2'd1;

	localparam logic [H2_W-1:0] H2_RESET = 32'd429497;

	localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_MUL,
		ALU_ACC,
		ALU_D3_FIRST,
		ALU_D3_NEXT,
		ALU_DIV_LOAD,
		ALU_DIV_STEP
	} alu_op_t;

	typedef struct packed {
		alu_op_t             op;
		logic [MUL_W-1:0]    mul_a;
		logic [MUL_W-1:0]    mul_b;
		logic                acc_clr;
		logic                acc_sub;
		logic                acc_hi;
		logic [D3_W-1:0]     d3_in;
		logic [ACC_W-1:0]    div_num;
		logic [CMAG_W-1:0]   divisor;
	} alu_cmd_t;

	typedef struct packed {
		logic [PROD_W-1:0]       prod;
		logic signed [ACC_W-1:0] acc;
		logic [D3_W-1:0]         d3q;
		logic [QUO_W-1:0]        quo;
	} alu_res_t;

endpackage

`default_nettype wire

>>> design/numsch_in_if.sv
`default_nettype none

interface numsch_in_if;
	import numsch_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [ACTION_W-1:0]       action;
	logic signed [VALUE_W-1:0] potential_sample;
	logic signed [VALUE_W-1:0] load_re;
	logic signed [VALUE_W-1:0] load_im;

	modport source (output valid, action, potential_sample, load_re, load_im, input ready);
	modport sink (input valid, action, potential_sample, load_re, load_im, output ready);
endinterface

`default_nettype wire

>>> design/numsch_out_if.sv
`default_nettype none

interface numsch_out_if;
	import numsch_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] wave_re;
	logic signed [VALUE_W-1:0] wave_im;
	logic                      saturated;

	modport source (output valid, wave_re, wave_im, saturated, input ready);
	modport sink (input valid, wave_re, wave_im, saturated, output ready);
endinterface

`default_nettype wire

>>> design/numsch_cfg_if.sv
`default_nettype none

interface numsch_cfg_if;
	import numsch_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/numsch_alu.sv
`default_nettype none

module numsch_alu (
	input  wire logic                clk,
	input  wire numsch_pkg::alu_cmd_t cmd,
	output numsch_pkg::alu_res_t     res
);
	import numsch_pkg::*;

	logic [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [D3_W-1:0]         d3_q;
	logic [1:0]              d3r_q;
	logic [REM_W-1:0]        rem_q;
	logic [QUO_W-1:0]        nq_q;
	logic [CMAG_W-1:0]       dvs_q;

	// Divide a six-bit value (remainder and one nibble) by three.
	// Multiplying by 43/128 is exact for values below 48.
	function automatic logic [5:0] div3_nib(input logic [1:0] r, input logic [3:0] n);
		logic [5:0]  v;
		logic [11:0] m;
		logic [3:0]  q;
		logic [5:0]  rr;
		v  = {r, n};
		m  = {6'd0, v} * 12'd43;
		q  = m[10:7];
		rr = v - {1'b0, q, 1'b0} - {2'b00, q};
		return {q, rr[1:0]};
	endfunction

	// One 32-bit word divided by three, a nibble at a time.
	function automatic logic [QUO_W+1:0] div3_word(input logic [1:0] r,
			input logic [QUO_W-1:0] w);
		logic [QUO_W-1:0] q;
		logic [1:0]       rr;
		logic [5:0]       st;
		q  = '0;
		rr = r;
		for (int i = QUO_W / 4 - 1; i >= 0; i--) begin
			st = div3_nib(rr, w[i*4 +: 4]);
			q[i*4 +: 4] = st[5:2];
			rr = st[1:0];
		end
		return {q, rr};
	endfunction

	logic [ACC_W-1:0]  acc_x;
	logic [ACC_W-1:0]  acc_base;
	logic [ACC_W-1:0]  acc_next;
	logic [QUO_W-1:0]  d3_chunk;
	logic [1:0]        d3_rin;
	logic [QUO_W+1:0]  d3_out;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// Accumulate, divide-by-three and long-division step logic.
	always_comb begin
		acc_x    = cmd.acc_hi ? ACC_W'({prod_q, {MUL_W{1'b0}}}) : ACC_W'(prod_q);
		acc_base = cmd.acc_clr ? '0 : acc_q;
		acc_next = cmd.acc_sub ? acc_base - acc_x : acc_base + acc_x;

		if (cmd.op == ALU_D3_FIRST) begin
			d3_chunk = cmd.d3_in[D3_W-1:QUO_W];
			d3_rin   = 2'd0;
		end else begin
			d3_chunk = d3_q[D3_W-1:QUO_W];
			d3_rin   = d3r_q;
		end
		d3_out = div3_word(d3_rin, d3_chunk);

		trial = {rem_q[REM_W-2:0], nq_q[QUO_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ALU_MUL: begin
				prod_q <= cmd.mul_a * cmd.mul_b;
			end
			ALU_ACC: begin
				acc_q <= acc_next;
			end
			ALU_D3_FIRST: begin
				d3_q  <= {cmd.d3_in[QUO_W-1:0], d3_out[QUO_W+1:2]};
				d3r_q <= d3_out[1:0];
			end
			ALU_D3_NEXT: begin
				d3_q  <= {d3_q[QUO_W-1:0], d3_out[QUO_W+1:2]};
				d3r_q <= d3_out[1:0];
			end
			ALU_DIV_LOAD: begin
				rem_q <= REM_W'(cmd.div_num[ACC_W-1:QUO_W]);
				nq_q  <= cmd.div_num[QUO_W-1:0];
				dvs_q <= cmd.divisor;
			end
			ALU_DIV_STEP: begin
				rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
				nq_q  <= {nq_q[QUO_W-2:0], fits};
			end
			default: begin
			end
		endcase
	end

	assign res.prod = prod_q;
	assign res.acc  = acc_q;
	assign res.d3q  = d3_q;
	assign res.quo  = nq_q;

endmodule

`default_nettype wire

>>> design/numerov_schrodinger_step.sv
`default_nettype none

// Numerov step engine for a complex 1D wave function in Q16.16. Load requests
// seed the older or newer history sample and return the loaded value through
// the output register. A step request forms three coefficient terms (multiply,
// two divide-by-three passes, sum) on the shared 32x32 multiplier and
// divide-by-three unit, then for the real and the imaginary part four partial
// products with accumulation and a restoring division, one quotient bit per
// cycle, or saturation for a zero divisor or overflow. The block accepts a
// request only while its sequencer is idle; a finished result may still be
// waiting in the output register when the next request is taken.
module numerov_schrodinger_step (
	input wire logic     clk,
	input wire logic     arst_n,
	numsch_in_if.sink    item,
	numsch_out_if.source result,
	numsch_cfg_if.sink   cfg
);
	import numsch_pkg::*;

	localparam logic [1:0] TERM_A = 2'd0;
	localparam logic [1:0] TERM_B = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;
	localparam logic [1:0] MUL_LAST = 2'd3;
	localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

	// Divide by 6 << FRAC_BITS is 3 << K6, by 12 << FRAC_BITS is 3 << K12.
	localparam int K6  = FRAC_BITS + 1;
	localparam int K12 = FRAC_BITS + 2;
	localparam logic [PROD_W+2:0] RND6  = (PROD_W+3)'(3) << (K6 - 1);
	localparam logic [PROD_W+2:0] RND12 = (PROD_W+3)'(3) << (K12 - 1);

	localparam logic [CMAG_W-1:0] COEF_ONE = CMAG_W'(64'd1 << 32);
	localparam logic [CMAG_W-1:0] COEF_TWO = CMAG_W'(64'd2 << 32);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TMUL,
		ST_TD3A,
		ST_TD3B,
		ST_TCOEF,
		ST_MUL,
		ST_ACC,
		ST_DABS,
		ST_DCHK,
		ST_DSTEP,
		ST_DEND,
		ST_FIN,
		ST_PUSH
	} state_t;

	state_t              state_q;
	logic [1:0]          ti_q;
	logic                ci_q;
	logic [1:0]          mi_q;
	logic [4:0]          cnt_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [H2_W-1:0]     h2_q;
	logic [VALUE_W-1:0]  prev_re_q, prev_im_q, older_re_q, older_im_q;
	logic [VALUE_W-1:0]  f_prev_q, f_older_q, fk_q;
	logic                sat_q;
	logic [VALUE_W-1:0]  res_re_q, res_im_q;
	logic [CMAG_W-1:0]   coef_mag_q [0:2];
	logic                coef_neg_q [0:2];
	logic [ACC_W-1:0]    mag_q;
	logic                accneg_q;
	logic                out_valid_q;
	logic [VALUE_W-1:0]  out_re_q, out_im_q;
	logic                out_sat_q;

	alu_cmd_t cmd;
	alu_res_t alu;

	numsch_alu u_alu (
		.clk (clk),
		.cmd (cmd),
		.res (alu)
	);

	function automatic logic [VALUE_W-1:0] enc(input logic neg, input logic [VALUE_W-1:0] mag);
		return neg ? ~mag + 1'b1 : mag;
	endfunction

	// F = 2 (V - E), saturated to the value range.
	logic signed [VALUE_W+1:0] diff;
	logic                      fsat;
	logic [VALUE_W-1:0]        fk;

	always_comb begin
		diff = {{2{item.potential_sample[VALUE_W-1]}}, item.potential_sample}
			- {3'b000, energy_q};
		fsat = !((&diff[VALUE_W+1:VALUE_W-2]) || !(|diff[VALUE_W+1:VALUE_W-2]));
		if (fsat) begin
			fk = diff[VALUE_W+1] ? VAL_MIN : VAL_MAX;
		end else begin
			fk = {diff[VALUE_W-2:0], 1'b0};
		end
	end

	// Coefficient term: F selection, scaling and rounding.
	logic [VALUE_W-1:0] fsel, fmag;
	logic               fneg, tneg;
	logic [PROD_W+2:0]  np, y67;
	logic [CMAG_W-1:0]  tval, cbase, cmag;
	logic               cneg;

	always_comb begin
		case (ti_q)
			TERM_A:  fsel = f_prev_q;
			TERM_B:  fsel = f_older_q;
			default: fsel = fk_q;
		endcase
		fneg = fsel[VALUE_W-1];
		fmag = fneg ? ~fsel + 1'b1 : fsel;

		if (ti_q == TERM_A) begin
			np  = ({3'b000, alu.prod} << 2) + {3'b000, alu.prod};
			y67 = (np + RND6) >> K6;
		end else begin
			np  = {3'b000, alu.prod};
			y67 = (np + RND12) >> K12;
		end

		tval  = alu.d3q[CMAG_W-1:0];
		cbase = (ti_q == TERM_A) ? COEF_TWO : COEF_ONE;
		tneg  = (ti_q == TERM_A) ? fneg : !fneg;
		if (!tneg) begin
			cneg = 1'b0;
			cmag = cbase + tval;
		end else if (tval <= cbase) begin
			cneg = 1'b0;
			cmag = cbase - tval;
		end else begin
			cneg = 1'b1;
			cmag = tval - cbase;
		end
	end

	// Numerator products and the final division.
	logic [VALUE_W-1:0] x1, x2, x1mag, x2mag;
	logic               s1, s2;
	logic [ACC_W-1:0]   numer;
	logic               ovf, dzero, rneg;
	logic [VALUE_W-1:0] qmag;
	logic               qsat;
	logic               part_done;
	logic [VALUE_W-1:0] part_val;
	logic               part_sat;

	always_comb begin
		x1    = ci_q ? prev_im_q : prev_re_q;
		x2    = ci_q ? older_im_q : older_re_q;
		x1mag = x1[VALUE_W-1] ? ~x1 + 1'b1 : x1;
		x2mag = x2[VALUE_W-1] ? ~x2 + 1'b1 : x2;
		s1    = coef_neg_q[TERM_A] ^ x1[VALUE_W-1];
		s2    = !(coef_neg_q[TERM_B] ^ x2[VALUE_W-1]);

		numer = mag_q + ACC_W'(coef_mag_q[TERM_D] >> 1);
		ovf   = numer[ACC_W-1:QUO_W] >= {1'b0, coef_mag_q[TERM_D]};
		dzero = coef_mag_q[TERM_D] == '0;
		rneg  = accneg_q ^ coef_neg_q[TERM_D];

		qsat = rneg ? (alu.quo > VAL_MIN) : (alu.quo > VAL_MAX);
		qmag = qsat ? (rneg ? VAL_MIN : VAL_MAX) : alu.quo;

		part_done = 1'b0;
		part_val  = '0;
		part_sat  = 1'b0;
		if (state_q == ST_DCHK) begin
			if (dzero) begin
				part_done = 1'b1;
				part_sat  = 1'b1;
				part_val  = (mag_q == '0) ? '0 : (accneg_q ? VAL_MIN : VAL_MAX);
			end else if (ovf) begin
				part_done = 1'b1;
				part_sat  = 1'b1;
				part_val  = rneg ? VAL_MIN : VAL_MAX;
			end
		end else if (state_q == ST_DEND) begin
			part_done = 1'b1;
			part_sat  = qsat;
			part_val  = enc(rneg, qmag);
		end
	end

	// Commands to the shared unit.
	always_comb begin
		cmd         = '0;
		cmd.op      = ALU_NOP;
		cmd.d3_in   = y67[D3_W-1:0];
		cmd.div_num = numer;
		cmd.divisor = coef_mag_q[TERM_D];
		case (state_q)
			ST_TMUL: begin
				cmd.op    = ALU_MUL;
				cmd.mul_a = h2_q;
				cmd.mul_b = fmag;
			end
			ST_TD3A: cmd.op = ALU_D3_FIRST;
			ST_TD3B: cmd.op = ALU_D3_NEXT;
			ST_MUL: begin
				cmd.op = ALU_MUL;
				case (mi_q)
					2'd0: begin
						cmd.mul_a = coef_mag_q[TERM_A][MUL_W-1:0];
						cmd.mul_b = x1mag;
					end
					2'd1: begin
						cmd.mul_a = MUL_W'(coef_mag_q[TERM_A][CMAG_W-1:MUL_W]);
						cmd.mul_b = x1mag;
					end
					2'd2: begin
						cmd.mul_a = coef_mag_q[TERM_B][MUL_W-1:0];
						cmd.mul_b = x2mag;
					end
					default: begin
						cmd.mul_a = MUL_W'(coef_mag_q[TERM_B][CMAG_W-1:MUL_W]);
						cmd.mul_b = x2mag;
					end
				endcase
			end
			ST_ACC: begin
				cmd.op      = ALU_ACC;
				cmd.acc_clr = mi_q == 2'd0;
				cmd.acc_sub = mi_q[1] ? s2 : s1;
				cmd.acc_hi  = mi_q[0];
			end
			ST_DCHK: begin
				if (!dzero && !ovf) begin
					cmd.op = ALU_DIV_LOAD;
				end
			end
			ST_DSTEP: cmd.op = ALU_DIV_STEP;
			default: begin
			end
		endcase
	end

	assign item.ready     = state_q == ST_IDLE;
	assign cfg.ready      = 1'b1;
	assign result.valid     = out_valid_q;
	assign result.wave_re   = out_re_q;
	assign result.wave_im   = out_im_q;
	assign result.saturated = out_sat_q;

	// Sequencer, history and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ti_q        <= '0;
			ci_q        <= 1'b0;
			mi_q        <= '0;
			cnt_q       <= '0;
			energy_q    <= '0;
			h2_q        <= H2_RESET;
			prev_re_q   <= '0;
			prev_im_q   <= '0;
			older_re_q  <= '0;
			older_im_q  <= '0;
			f_prev_q    <= '0;
			f_older_q   <= '0;
			fk_q        <= '0;
			sat_q       <= 1'b0;
			res_re_q    <= '0;
			res_im_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				coef_mag_q[i] <= '0;
				coef_neg_q[i] <= 1'b0;
			end
			mag_q       <= '0;
			accneg_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_re_q    <= '0;
			out_im_q    <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_ENERGY:    energy_q <= cfg.data[ENERGY_W-1:0];
					REG_H_SQUARED: h2_q <= cfg.data[H2_W-1:0];
					default: begin
					end
				endcase
			end

			// The output register takes a finished request when it is empty or as the previous one leaves.
			if (state_q == ST_PUSH && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
				out_re_q    <= res_re_q;
				out_im_q    <= res_im_q;
				out_sat_q   <= sat_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (part_done) begin
				if (ci_q) begin
					res_im_q <= part_val;
				end else begin
					res_re_q <= part_val;
				end
				sat_q <= sat_q | part_sat;
				if (!ci_q) begin
					ci_q    <= 1'b1;
					mi_q    <= '0;
					state_q <= ST_MUL;
				end else begin
					state_q <= ST_FIN;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						sat_q <= fsat;
						case (item.action)
							ACT_LOAD_OLDER: begin
								older_re_q <= item.load_re;
								older_im_q <= item.load_im;
								f_older_q  <= fk;
								res_re_q   <= item.load_re;
								res_im_q   <= item.load_im;
								state_q    <= ST_PUSH;
							end
							ACT_LOAD_PREV: begin
								prev_re_q <= item.load_re;
								prev_im_q <= item.load_im;
								f_prev_q  <= fk;
								res_re_q  <= item.load_re;
								res_im_q  <= item.load_im;
								state_q   <= ST_PUSH;
							end
							ACT_STEP: begin
								fk_q    <= fk;
								ti_q    <= TERM_A;
								state_q <= ST_TMUL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TMUL: state_q <= ST_TD3A;
				ST_TD3A: state_q <= ST_TD3B;
				ST_TD3B: state_q <= ST_TCOEF;
				ST_TCOEF: begin
					coef_mag_q[ti_q] <= cmag;
					coef_neg_q[ti_q] <= cneg;
					if (ti_q == TERM_D) begin
						ci_q    <= 1'b0;
						mi_q    <= '0;
						state_q <= ST_MUL;
					end else begin
						ti_q    <= ti_q + 2'd1;
						state_q <= ST_TMUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (mi_q == MUL_LAST) begin
						state_q <= ST_DABS;
					end else begin
						mi_q    <= mi_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_DABS: begin
					accneg_q <= alu.acc[ACC_W-1];
					mag_q    <= alu.acc[ACC_W-1] ? ~alu.acc + 1'b1 : alu.acc;
					state_q  <= ST_DCHK;
				end
				ST_DCHK: begin
					if (!part_done) begin
						cnt_q   <= '0;
						state_q <= ST_DSTEP;
					end
				end
				ST_DSTEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_DEND;
					end
				end
				ST_FIN: begin
					older_re_q <= prev_re_q;
					older_im_q <= prev_im_q;
					f_older_q  <= f_prev_q;
					prev_re_q  <= res_re_q;
					prev_im_q  <= res_im_q;
					f_prev_q   <= fk_q;
					state_q    <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!out_valid_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/tb_numerov_schrodinger_step.sv
module tb_numerov_schrodinger_step;
	timeunit 1ns;
	timeprecision 1ps;
	import numsch_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 120;
	localparam logic [127:0] COEF_CAP = (128'd1 << 62) - 128'd1;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [VALUE_W-1:0] re;
		logic [VALUE_W-1:0] im;
		logic               sat;
	} wave_t;

	logic clk;
	logic arst_n;

	numsch_in_if  in_ch();
	numsch_out_if out_ch();
	numsch_cfg_if cfg_ch();

	numerov_schrodinger_step uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (in_ch.sink),
		.result(out_ch.source),
		.cfg   (cfg_ch.sink)
	);

	// Shadow copy of the block's registers and history.
	logic [ENERGY_W-1:0] energy_m;
	logic [H2_W-1:0]     h2_m;
	logic [VALUE_W-1:0]  prev_re_m, prev_im_m, older_re_m, older_im_m;
	logic [VALUE_W-1:0]  f_prev_m, f_older_m;
	logic                sat_m;

	wave_t wave_due_q[$];
	int    fail_count = 0;
	int    idle_cycles = 0;
	int    tx_idle_pct = 0;
	int    rx_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// F = 2 (V - E), saturated to the value range.
	function automatic logic [VALUE_W-1:0] force_term(input logic signed [VALUE_W-1:0] v);
		logic signed [63:0] vs;
		logic signed [63:0] es;
		logic signed [63:0] t;
		vs = v;
		es = {33'd0, energy_m};
		t = (vs - es) <<< 1;
		if (t > 64'sh7fffffff) begin
			sat_m = 1'b1;
			return VAL_MAX;
		end
		if (t < -64'sh80000000) begin
			sat_m = 1'b1;
			return VAL_MIN;
		end
		return t[VALUE_W-1:0];
	endfunction

	// Rounded num/den * h2 * |F| with 32 fraction bits, capped.
	function automatic logic [127:0] h2_term(input logic [VALUE_W-1:0] f, input int num,
			input int den);
		logic [127:0] fmag;
		logic [127:0] dv;
		logic [127:0] q;
		fmag = {96'd0, f[VALUE_W-1] ? (~f + 1'b1) : f};
		dv = 128'(den) << FRAC_BITS;
		q = ({96'd0, h2_m} * fmag * 128'(num) + (dv >> 1)) / dv;
		if (q > COEF_CAP) begin
			sat_m = 1'b1;
			return COEF_CAP;
		end
		return q;
	endfunction

	function automatic logic signed [127:0] coef(input logic [127:0] base, input logic tneg,
			input logic [127:0] t);
		logic signed [127:0] c;
		c = tneg ? $signed(base - t) : $signed(base + t);
		if (c > $signed(COEF_CAP)) begin
			c = COEF_CAP;
			sat_m = 1'b1;
		end else if (c < -$signed(COEF_CAP)) begin
			c = -$signed(COEF_CAP);
			sat_m = 1'b1;
		end
		return c;
	endfunction

	// (a p1 - b p2) / d, rounded half away from zero and saturated.
	function automatic logic [VALUE_W-1:0] recur_part(input logic signed [127:0] a,
			input logic signed [VALUE_W-1:0] p1, input logic signed [127:0] b,
			input logic signed [VALUE_W-1:0] p2, input logic signed [127:0] d);
		logic signed [127:0] x1, x2, df;
		logic [127:0] dm, dmag, q, lim;
		logic dneg, rneg;
		x1 = p1;
		x2 = p2;
		df = a * x1 - b * x2;
		dneg = df < 0;
		dm = dneg ? -df : df;
		if (d == 0) begin
			sat_m = 1'b1;
			if (dm == 0)
				return '0;
			return dneg ? VAL_MIN : VAL_MAX;
		end
		dmag = (d < 0) ? -d : d;
		q = (dm + (dmag >> 1)) / dmag;
		rneg = dneg != (d < 0);
		lim = rneg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) begin
			sat_m = 1'b1;
			q = lim;
		end
		return rneg ? (~q[VALUE_W-1:0] + 1'b1) : q[VALUE_W-1:0];
	endfunction

	// Advances the shadow state for one accepted request and queues its result; the unused action does neither.
	task automatic numerov_predict(input logic [ACTION_W-1:0] act,
			input logic [VALUE_W-1:0] v, input logic [VALUE_W-1:0] re,
			input logic [VALUE_W-1:0] im);
		logic [VALUE_W-1:0] fk;
		logic signed [127:0] ca, cb, cd;
		wave_t w;
		if (act == ACT_UNUSED)
			return;
		sat_m = 1'b0;
		fk = force_term(v);
		case (act)
			ACT_LOAD_OLDER: begin
				older_re_m = re;
				older_im_m = im;
				f_older_m = fk;
				w.re = re;
				w.im = im;
			end
			ACT_LOAD_PREV: begin
				prev_re_m = re;
				prev_im_m = im;
				f_prev_m = fk;
				w.re = re;
				w.im = im;
			end
			default: begin
				ca = coef(128'd1 << 33, f_prev_m[VALUE_W-1], h2_term(f_prev_m, 5, 6));
				cb = coef(128'd1 << 32, !f_older_m[VALUE_W-1], h2_term(f_older_m, 1, 12));
				cd = coef(128'd1 << 32, !fk[VALUE_W-1], h2_term(fk, 1, 12));
				w.re = recur_part(ca, prev_re_m, cb, older_re_m, cd);
				w.im = recur_part(ca, prev_im_m, cb, older_im_m, cd);
				older_re_m = prev_re_m;
				older_im_m = prev_im_m;
				f_older_m = f_prev_m;
				prev_re_m = w.re;
				prev_im_m = w.im;
				f_prev_m = fk;
			end
		endcase
		w.sat = sat_m;
		wave_due_q.push_back(w);
	endtask

	// Sends one request; returns at the edge that accepted it with valid still high.
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] v,
			input logic [VALUE_W-1:0] re, input logic [VALUE_W-1:0] im);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.potential_sample <= v;
		in_ch.load_re <= re;
		in_ch.load_im <= im;
		do @(negedge clk); while (!in_ch.ready);
		numerov_predict(act, v, re, im);
		@(posedge clk);
	endtask

	// Holds off the sender until every queued result has come back.
	task automatic drain;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (wave_due_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(negedge clk); while (!cfg_ch.ready);
		if (idx == REG_ENERGY)
			energy_m = val[ENERGY_W-1:0];
		else if (idx == REG_H_SQUARED)
			h2_m = val;
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random value: wide, modest, small or extreme.
	function automatic logic [VALUE_W-1:0] rand_val;
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
			2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			default: return $signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000;
		endcase
	endfunction

	task automatic test_load_extremes;
		write_reg(REG_ENERGY, 32'd0);
		write_reg(REG_H_SQUARED, H2_RESET);
		send_item(ACT_LOAD_OLDER, 32'd0, VAL_MAX, VAL_MIN);
		send_item(ACT_LOAD_PREV, VAL_MAX, VAL_MIN, VAL_MAX);
		send_item(ACT_STEP, VAL_MIN, 32'd0, 32'd0);
		send_item(ACT_STEP, 32'd0, 32'hffff_ffff, 32'd1);
		send_item(ACT_STEP, 32'hffff_ffff, 32'd0, 32'd0);
		write_reg(REG_ENERGY, 32'h7fff_ffff);
		write_reg(REG_H_SQUARED, 32'hffff_ffff);
		send_item(ACT_LOAD_OLDER, VAL_MIN, 32'h0001_0000, 32'hffff_0000);
		send_item(ACT_LOAD_PREV, 32'd0, 32'h0002_0000, 32'h0000_8000);
		send_item(ACT_STEP, VAL_MAX, 32'd0, 32'd0);
		send_item(ACT_STEP, VAL_MIN, 32'd0, 32'd0);
	endtask

	// With h2 = 0.5 and F = 24 the divisor 1 - h2 F / 12 is exactly zero.
	task automatic test_zero_divisor;
		write_reg(REG_ENERGY, 32'd0);
		write_reg(REG_H_SQUARED, 32'h8000_0000);
		send_item(ACT_LOAD_OLDER, 32'd0, 32'h0005_0000, 32'hfffd_0000);
		send_item(ACT_LOAD_PREV, 32'd0, 32'h0007_0000, 32'd0);
		send_item(ACT_STEP, 32'h000c_0000, 32'd0, 32'd0);
		send_item(ACT_LOAD_OLDER, 32'd0, 32'd0, 32'd0);
		send_item(ACT_LOAD_PREV, 32'd0, 32'd0, 32'd0);
		send_item(ACT_STEP, 32'h000c_0000, 32'd0, 32'd0);
	endtask

	// The unused action must leave the history alone and return nothing.
	task automatic test_unused_action;
		send_item(ACT_UNUSED, 32'h1234_5678, 32'hdead_beef, 32'h0bad_f00d);
		send_item(ACT_STEP, 32'h0000_1000, 32'd0, 32'd0);
		send_item(ACT_UNUSED, VAL_MIN, VAL_MAX, VAL_MIN);
		send_item(ACT_LOAD_PREV, 32'd0, 32'h0000_4000, 32'hffff_c000);
	endtask

	// Mostly seeded runs of steps, with some stray requests and register changes.
	task automatic test_random_phase(input int n_items, input int tx_pct, input int rx_pct);
		int sent;
		int n_steps;
		int pick;
		sent = 0;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				send_item(ACT_UNUSED, $urandom, $urandom, $urandom);
			end else if (pick < 14) begin
				send_item(2'($urandom_range(2)), rand_val(), rand_val(), rand_val());
				sent++;
			end else if (pick < 17) begin
				write_reg(REG_ENERGY, $urandom_range(0, 32'h0010_0000));
				write_reg(REG_H_SQUARED, $urandom_range(1) ? $urandom : $urandom_range(0, 32'h00ff_ffff));
			end else begin
				send_item(ACT_LOAD_OLDER, rand_val(), rand_val(), rand_val());
				send_item(ACT_LOAD_PREV, rand_val(), rand_val(), rand_val());
				n_steps = $urandom_range(1, 8);
				repeat (n_steps)
					send_item(ACT_STEP, rand_val(), $urandom, $urandom);
				sent += 2 + n_steps;
			end
			if (sent > n_items / 2 && sent < n_items / 2 + 6)
				drain();
		end
		drain();
	endtask

	// Result checker and stall watchdog, sampled mid-cycle.
	always @(negedge clk) begin
		wave_t w;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** numerov_schrodinger_step: FAILED **");
				$finish;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (wave_due_q.size() == 0) begin
					$display("%0t unexpected result re %h im %h sat %b", $time,
						out_ch.wave_re, out_ch.wave_im, out_ch.saturated);
					fail_count++;
				end else begin
					w = wave_due_q.pop_front();
					if (out_ch.wave_re !== w.re) begin
						$display("%0t wave_re expected %h actual %h", $time, w.re, out_ch.wave_re);
						fail_count++;
					end
					if (out_ch.wave_im !== w.im) begin
						$display("%0t wave_im expected %h actual %h", $time, w.im, out_ch.wave_im);
						fail_count++;
					end
					if (out_ch.saturated !== w.sat) begin
						$display("%0t saturated expected %b actual %b", $time, w.sat,
							out_ch.saturated);
						fail_count++;
					end
				end
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.action <= ACT_LOAD_OLDER;
		in_ch.potential_sample <= '0;
		in_ch.load_re <= '0;
		in_ch.load_im <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_ENERGY;
		cfg_ch.data <= '0;
		energy_m = '0;
		h2_m = H2_RESET;
		prev_re_m = '0;
		prev_im_m = '0;
		older_re_m = '0;
		older_im_m = '0;
		f_prev_m = '0;
		f_older_m = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A step straight out of reset runs on the zero history.
		send_item(ACT_STEP, 32'h0001_0000, 32'd0, 32'd0);
		test_load_extremes();
		test_zero_divisor();
		test_unused_action();
		drain();

		write_reg(REG_ENERGY, 32'h0002_0000);
		write_reg(REG_H_SQUARED, H2_RESET);
		test_random_phase(400, 15, 85);
		write_reg(REG_ENERGY, 32'h7fff_ffff);
		write_reg(REG_H_SQUARED, 32'hffff_ffff);
		test_random_phase(400, 85, 15);
		write_reg(REG_ENERGY, 32'd0);
		write_reg(REG_H_SQUARED, 32'd0);
		test_random_phase(420, 0, 0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && wave_due_q.size() == 0)
			$display("** numerov_schrodinger_step: PASSED **");
		else
			$display("** numerov_schrodinger_step: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
design/numsch_pkg.sv
design/numsch_in_if.sv
design/numsch_out_if.sv
design/numsch_cfg_if.sv
design/numsch_alu.sv
design/numerov_schrodinger_step.sv
tb/sv/tb_numerov_schrodinger_step.sv
